// File: rtl/ppve_pkg.sv
// shared types, constants and the saturation helper of the polynomial evaluator
package ppve_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_DEGREE = 7;
	localparam int NUM_COEFFS = MAX_DEGREE + 1;
	localparam int NUM_CELLS  = MAX_DEGREE;
	localparam int NUM_DERIV  = MAX_DEGREE;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int SUM_W      = PROD_W - FRAC_BITS + 1;
	localparam int REG_W      = $clog2(NUM_COEFFS);
	localparam int ADDR_W     = REG_W + 2;
	localparam int DMUL_W     = DATA_W + REG_W + 1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DMUL_W-1:0] dmul_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// one item moving down the row of cells
	typedef struct packed {
		logic  valid;
		logic  ov;
		word_t t;
		word_t acc_p;
		word_t acc_v;
	} lane_t;

	typedef struct packed {
		logic  ov;
		word_t val;
	} sat_t;

	// clamp a wide signed value to the data word, flag when clamped
	function automatic sat_t sat_word(input sum_t x);
		sat_t r;
		if (x > sum_t'(WORD_MAX)) begin
			r.ov  = 1'b1;
			r.val = WORD_MAX;
		end else if (x < sum_t'(WORD_MIN)) begin
			r.ov  = 1'b1;
			r.val = WORD_MIN;
		end else begin
			r.ov  = 1'b0;
			r.val = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/ppve_regs.sv
// coefficient registers with derivative coefficients formed at write time
module ppve_regs
	import ppve_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output word_t             coeff [NUM_COEFFS],
	output word_t             deriv [NUM_DERIV],
	output logic              deriv_ov
);

	word_t             coeff_q  [NUM_COEFFS];
	word_t             deriv_q  [NUM_DERIV];
	logic [NUM_DERIV-1:0] deriv_ov_q;
	logic              wr_en;
	logic [REG_W-1:0]  idx;
	dmul_t             dprod;
	sat_t              dsat;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[ADDR_W-1:2];

	// derivative coefficient i-1 = i * c_i, clamped
	assign dprod = dmul_t'($signed({1'b0, idx})) * dmul_t'($signed(pwdata));
	assign dsat  = sat_word(sum_t'(dprod));

	// register write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFFS; i++) coeff_q[i] <= '0;
			for (int i = 0; i < NUM_DERIV; i++) deriv_q[i] <= '0;
			deriv_ov_q <= '0;
		end else if (wr_en) begin
			coeff_q[idx] <= $signed(pwdata);
			if (idx != '0) begin
				deriv_q[REG_W'(idx - 1'b1)]    <= dsat.val;
				deriv_ov_q[REG_W'(idx - 1'b1)] <= dsat.ov;
			end
		end
	end

	assign prdata   = coeff_q[idx];
	assign coeff    = coeff_q;
	assign deriv    = deriv_q;
	assign deriv_ov = |deriv_ov_q;

endmodule

// File: rtl/ppve_cell.sv
// one horner step for position and velocity: multiply, then scale, add and clamp
module ppve_cell
	import ppve_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  lane_t lane_in,
	input  word_t coef_p,
	input  word_t coef_v,
	output lane_t lane_out
);

	logic  valid_s1;
	logic  ov_s1;
	word_t t_s1;
	prod_t prod_p_s1;
	prod_t prod_v_s1;
	sum_t  sum_p;
	sum_t  sum_v;
	sat_t  sat_p;
	sat_t  sat_v;
	logic  valid_s2;
	lane_t data_s2;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= lane_in.valid;
		end
	end

	// stage 1 products
	always_ff @(posedge clk) begin
		ov_s1     <= lane_in.ov;
		t_s1      <= lane_in.t;
		prod_p_s1 <= lane_in.acc_p * lane_in.t;
		prod_v_s1 <= lane_in.acc_v * lane_in.t;
	end

	// floor scaling is an arithmetic shift, then add coefficient and clamp
	assign sum_p = sum_t'(prod_p_s1 >>> FRAC_BITS) + sum_t'(coef_p);
	assign sum_v = sum_t'(prod_v_s1 >>> FRAC_BITS) + sum_t'(coef_v);
	assign sat_p = sat_word(sum_p);
	assign sat_v = sat_word(sum_v);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 accumulators
	always_ff @(posedge clk) begin
		data_s2.valid <= 1'b0;
		data_s2.ov    <= ov_s1 | sat_p.ov | sat_v.ov;
		data_s2.t     <= t_s1;
		data_s2.acc_p <= sat_p.val;
		data_s2.acc_v <= sat_v.val;
	end

	always_comb begin
		lane_out       = data_s2;
		lane_out.valid = valid_s2;
	end

endmodule

// File: rtl/polynomial_position_velocity_eval.sv
// top level of the degree-7 polynomial position and velocity evaluator
//
// A time sample is taken on every cycle in which start is high (busy is always
// low), and its position, velocity and overflow flag leave the last cell
// with done high for exactly one cycle; the receiver cannot stall, so results
// must be captured when done is high. Each sample passes through a row of seven
// horner cells, each two register stages deep (a 32x32 multiply, then scale,
// add and clamp); both polynomials advance through the same cells together.
// Coefficients are written through the APB port at byte address 4*i and must
// only change while no sample is in flight; overflow also reports derivative
// coefficients that clamped when written.
module polynomial_position_velocity_eval
	import ppve_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DATA_W-1:0] time_value,
	output logic              done,
	output logic [DATA_W-1:0] position,
	output logic [DATA_W-1:0] velocity,
	output logic              overflow,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	word_t coeff [NUM_COEFFS];
	word_t deriv [NUM_DERIV];
	logic  deriv_ov;
	lane_t lane  [NUM_CELLS+1];

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// configuration registers
	ppve_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.coeff    (coeff),
		.deriv    (deriv),
		.deriv_ov (deriv_ov)
	);

	// chain entry: position starts at the top coefficient, velocity at zero
	always_comb begin
		lane[0].valid = start & ~busy;
		lane[0].ov    = deriv_ov;
		lane[0].t     = $signed(time_value);
		lane[0].acc_p = coeff[MAX_DEGREE];
		lane[0].acc_v = '0;
	end

	// row of horner cells, highest power first
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		ppve_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.lane_in  (lane[k]),
			.coef_p   (coeff[MAX_DEGREE-1-k]),
			.coef_v   (deriv[NUM_DERIV-1-k]),
			.lane_out (lane[k+1])
		);
	end

	// result transfer
	assign done     = lane[NUM_CELLS].valid;
	assign position = lane[NUM_CELLS].acc_p;
	assign velocity = lane[NUM_CELLS].acc_v;
	assign overflow = lane[NUM_CELLS].ov;

endmodule
